FILE: rtl/tpsr_pkg.sv
// Package for the two-axis PID stepper-rate core: register codes, reset values,
// field widths and the stepper timing constants.
// No dependencies; imported by two_axis_pid_stepper_rate_core.
`timescale 1ns / 1ps

package tpsr_pkg;

	// Default coordinate width.
	localparam int COORD_BITS_DEF = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_AIM_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AIM_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIM  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM  = 3'd6;

	// Register widths.
	localparam int GAIN_W = 10;
	localparam int ILIM_W = 12;
	localparam int OLIM_W = 15;

	// Reset values.
	localparam int AIM_X_RST            = 75;
	localparam int AIM_Y_RST            = 60;
	localparam logic [GAIN_W-1:0] GAIN_P_RST = 10'd400;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 10'd4;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 10'd0;
	localparam logic [ILIM_W-1:0] ILIM_RST   = 12'd100;
	localparam logic [OLIM_W-1:0] OLIM_RST   = 15'd9500;

	// Internal widths.
	localparam int ACC_W   = 13;  // clamped integral
	localparam int DRIVE_W = 16;
	localparam int MAG_W   = 15;
	localparam int PRE_W   = 14;

	// Stepper timing.
	localparam int STEP_CLOCK   = 1000000;
	localparam int PRESCALE_MAX = 10000;
	localparam int NEAR_LIMIT   = 6;

endpackage

FILE: rtl/two_axis_pid_stepper_rate_core.sv
// Two-axis PID stepper-rate core: spot error, clamped PID drive and stepper
// prescaler per axis, computed by one shared multiplier and a radix-2 divider.
// Depends on tpsr_pkg.
`timescale 1ns / 1ps

// Usage
//   s_axis carries one spot position per item: tdata = {spot_y, spot_x}.
//   m_axis returns one result item per input item (field list at the port).
//   cfg_* writes register cfg_index with cfg_data; cfg_ready is always high.
//   Write registers only while the core is idle with no result pending.
// Sequencing
//   An item runs the two axes one after the other through a small sequencer:
//   error/integral step, three multiply-accumulate steps on the single shared
//   multiplier, drive clamp, then 14 restoring-division steps when the drive
//   magnitude is 100 or more, and one update step; the output step follows
//   the y axis. The item is taken in the idle state, and the divider's
//   bit-serial loop is the longest part of the sequence.
//   s_axis_tready is high only while the sequencer is idle.
// Reset
//   arst_n clears integrals, previous errors, held direction and prescaler and
//   loads the default gains, limits and aim point.
// Stall
//   A finished result sits in the output register; the next item is accepted
//   at once, and its result waits in the last step until the slot frees up.

module two_axis_pid_stepper_rate_core #(
	parameter int COORD_BITS = tpsr_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [COORD_BITS-1:0] spot_x, [2*COORD_BITS-1:COORD_BITS] spot_y, zero pad
	input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// from bit 0: error_x, error_y (COORD_BITS+1 each), drive_x, drive_y (16 each),
	// dir_x, dir_y, stop_x, stop_y, prescale_x, prescale_y (14 each), on_target, pad
	output logic [((2*COORD_BITS+67+7)/8)*8-1:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tpsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tpsr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tpsr_pkg::*;

	localparam int EW      = COORD_BITS + 1;
	localparam int AW      = ((EW > ACC_W) ? EW : ACC_W) + 1;
	localparam int MW      = ((EW + 1 > ACC_W) ? EW + 1 : ACC_W);
	localparam int PW      = MW + GAIN_W + 1;
	localparam int SW      = MW + GAIN_W + 3;
	localparam int OUT_RAW = 2 * EW + 2 * DRIVE_W + 4 + 2 * PRE_W + 1;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
	localparam int OUT_PAD = OUT_W - OUT_RAW;
	localparam int SAT_MAG = STEP_CLOCK / (PRESCALE_MAX + 1);
	localparam int CNT_W   = $clog2(PRE_W);
	localparam logic [PRE_W-1:0] DIV_LOW  = PRE_W'(STEP_CLOCK);
	localparam logic [MAG_W-1:0] REM_INIT = MAG_W'(STEP_CLOCK >> PRE_W);
	localparam logic [CNT_W-1:0] CNT_TOP  = CNT_W'(PRE_W - 1);
	localparam logic [CNT_W-1:0] CNT_ZERO = '0;
	localparam logic [PRE_W-1:0] PRE_SAT  = PRE_W'(PRESCALE_MAX);
	localparam logic [MAG_W-1:0] MAG_SAT  = MAG_W'(SAT_MAG);
	localparam logic signed [EW-1:0] NEAR_POS = EW'(NEAR_LIMIT);
	localparam logic signed [EW-1:0] NEAR_NEG = -EW'(NEAR_LIMIT);

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ERR   = 4'd1;
	localparam logic [3:0] ST_MP    = 4'd2;
	localparam logic [3:0] ST_MD    = 4'd3;
	localparam logic [3:0] ST_MI    = 4'd4;
	localparam logic [3:0] ST_CLAMP = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_NEXT  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	// configuration registers
	logic [COORD_BITS-1:0] aim_x_q, aim_y_q;
	logic [GAIN_W-1:0]     gain_p_q, gain_i_q, gain_d_q;
	logic [ILIM_W-1:0]     ilim_q;
	logic [OLIM_W-1:0]     olim_q;

	// per-axis state, entry 0 is x, entry 1 is y
	logic signed [ACC_W-1:0]   accum_q [2];
	logic signed [EW-1:0]      prev_q [2];
	logic                      held_dir_q [2];
	logic [PRE_W-1:0]          held_pre_q [2];
	logic signed [DRIVE_W-1:0] drive_q [2];

	logic [3:0]              state_q;
	logic                    axis_q;
	logic [COORD_BITS-1:0]   spot_x_q, spot_y_q;
	logic signed [EW:0]      diff_q;
	logic signed [SW-1:0]    sum_q;
	logic [MAG_W-1:0]        mag_q;
	logic [MAG_W-1:0]        rem_q;
	logic [PRE_W-1:0]        quo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    m_tvalid_q;
	logic [OUT_W-1:0]        m_tdata_q;

	// error and integral step
	logic [COORD_BITS-1:0]   spot_sel, aim_sel;
	logic signed [EW-1:0]    err_c;
	logic signed [AW-1:0]    acc_raw, lim_ext;
	logic signed [ACC_W-1:0] acc_c;
	logic signed [EW:0]      diff_c;

	// shared multiplier
	logic [GAIN_W-1:0]       mul_gain;
	logic signed [MW-1:0]    mul_b;
	logic signed [PW-1:0]    prod_c;

	// drive clamp
	logic signed [SW-1:0]      olim_ext;
	logic signed [DRIVE_W-1:0] olim_s, drive_c, mag_full;

	// divider step
	logic [MAG_W:0] trial_c;
	logic           ge_c;

	logic signed [EW-1:0] err_x_out, err_y_out;
	logic                 near_c, out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign out_free      = !m_tvalid_q || m_axis_tready;

	always_comb begin
		spot_sel = axis_q ? spot_y_q : spot_x_q;
		aim_sel  = axis_q ? aim_y_q : aim_x_q;
		err_c    = $signed({1'b0, spot_sel}) - $signed({1'b0, aim_sel});
		lim_ext  = AW'($signed({1'b0, ilim_q}));
		acc_raw  = AW'(accum_q[axis_q]) + AW'(err_c);
		if (acc_raw > lim_ext) begin
			acc_c = ACC_W'(lim_ext);
		end else if (acc_raw < -lim_ext) begin
			acc_c = ACC_W'(-lim_ext);
		end else begin
			acc_c = ACC_W'(acc_raw);
		end
		diff_c = (EW + 1)'(err_c) - (EW + 1)'(prev_q[axis_q]);
	end

	always_comb begin
		case (state_q)
			ST_MP: begin
				mul_gain = gain_p_q;
				mul_b    = MW'(prev_q[axis_q]);
			end
			ST_MD: begin
				mul_gain = gain_d_q;
				mul_b    = MW'(diff_q);
			end
			default: begin
				mul_gain = gain_i_q;
				mul_b    = MW'(accum_q[axis_q]);
			end
		endcase
		prod_c = $signed({1'b0, mul_gain}) * mul_b;
	end

	always_comb begin
		olim_s   = $signed({1'b0, olim_q});
		olim_ext = SW'(olim_s);
		if (sum_q > olim_ext) begin
			drive_c = olim_s;
		end else if (sum_q < -olim_ext) begin
			drive_c = -olim_s;
		end else begin
			drive_c = DRIVE_W'(sum_q);
		end
		mag_full = (drive_c < 0) ? -drive_c : drive_c;
	end

	assign trial_c = {rem_q, DIV_LOW[cnt_q]};
	assign ge_c    = (trial_c >= {1'b0, mag_q});

	assign err_x_out = prev_q[0];
	assign err_y_out = prev_q[1];
	assign near_c    = (err_x_out < NEAR_POS) && (err_x_out > NEAR_NEG)
		&& (err_y_out < NEAR_POS) && (err_y_out > NEAR_NEG);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aim_x_q  <= COORD_BITS'(AIM_X_RST);
			aim_y_q  <= COORD_BITS'(AIM_Y_RST);
			gain_p_q <= GAIN_P_RST;
			gain_i_q <= GAIN_I_RST;
			gain_d_q <= GAIN_D_RST;
			ilim_q   <= ILIM_RST;
			olim_q   <= OLIM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_AIM_X:   aim_x_q  <= cfg_data[COORD_BITS-1:0];
				REG_AIM_Y:   aim_y_q  <= cfg_data[COORD_BITS-1:0];
				REG_GAIN_P:  gain_p_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:  gain_i_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:  gain_d_q <= cfg_data[GAIN_W-1:0];
				REG_INT_LIM: ilim_q   <= cfg_data[ILIM_W-1:0];
				REG_OUT_LIM: olim_q   <= cfg_data[OLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			axis_q        <= 1'b0;
			m_tvalid_q    <= 1'b0;
			accum_q[0]    <= '0;
			accum_q[1]    <= '0;
			prev_q[0]     <= '0;
			prev_q[1]     <= '0;
			held_dir_q[0] <= 1'b0;
			held_dir_q[1] <= 1'b0;
			held_pre_q[0] <= '0;
			held_pre_q[1] <= '0;
		end else begin
			// raise valid out of the output step, drop it once the item is taken
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						axis_q  <= 1'b0;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					// the new error replaces the previous one once the difference is taken
					accum_q[axis_q] <= acc_c;
					prev_q[axis_q]  <= err_c;
					state_q         <= ST_MP;
				end
				ST_MP:    state_q <= ST_MD;
				ST_MD:    state_q <= ST_MI;
				ST_MI:    state_q <= ST_CLAMP;
				ST_CLAMP: begin
					if (drive_c == 0) begin
						state_q <= ST_NEXT;
					end else if (mag_full[MAG_W-1:0] <= MAG_SAT) begin
						state_q <= ST_NEXT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_ZERO) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					// hold direction and prescaler across a zero drive
					if (drive_q[axis_q] != 0) begin
						held_pre_q[axis_q] <= quo_q;
						held_dir_q[axis_q] <= (drive_q[axis_q] > 0) ^ axis_q;
					end
					if (axis_q) begin
						state_q <= ST_OUT;
					end else begin
						axis_q  <= 1'b1;
						state_q <= ST_ERR;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			spot_x_q <= s_axis_tdata[COORD_BITS-1:0];
			spot_y_q <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
		end
		if (state_q == ST_ERR) begin
			diff_q <= diff_c;
		end
		if (state_q == ST_MP) begin
			sum_q <= SW'(prod_c);
		end else if (state_q == ST_MD || state_q == ST_MI) begin
			sum_q <= sum_q + SW'(prod_c);
		end
		if (state_q == ST_CLAMP) begin
			drive_q[axis_q] <= drive_c;
			mag_q           <= mag_full[MAG_W-1:0];
			rem_q           <= REM_INIT;
			cnt_q           <= CNT_TOP;
			quo_q           <= PRE_SAT;
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge_c ? MAG_W'(trial_c - {1'b0, mag_q}) : trial_c[MAG_W-1:0];
			quo_q <= {quo_q[PRE_W-2:0], ge_c};
			cnt_q <= cnt_q - 1'b1;
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {{OUT_PAD{1'b0}}, near_c, held_pre_q[1], held_pre_q[0],
				(drive_q[1] == 0), (drive_q[0] == 0), held_dir_q[1], held_dir_q[0],
				drive_q[1], drive_q[0], err_y_out, err_x_out};
		end
	end

	// an accepted item always starts with the x-axis error step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_ERR && !axis_q))
		else $error("item accepted without starting the x axis");

	// divider only runs on magnitudes whose quotient fits the prescaler
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (mag_q > MAG_SAT && rem_q < mag_q))
		else $error("divider operands out of range");

	// held prescaler never exceeds the saturation value
	a_pre_max: assert property (@(posedge clk) disable iff (!arst_n)
		(held_pre_q[0] <= PRE_SAT) && (held_pre_q[1] <= PRE_SAT))
		else $error("held prescaler above saturation");

	// a result appears only out of the output step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");

endmodule
